@@ hw/rtl/metronome_beat_timer_top_assert.svh @@
// ----------------------------------------------------------------------------
// Metronome beat timer assertion macros
// Shared property forms for the checkers of the metronome beat timer.
// ----------------------------------------------------------------------------
`ifndef METRONOME_BEAT_TIMER_TOP_ASSERT_SVH
`define METRONOME_BEAT_TIMER_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MBT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define MBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mbt_pkg.sv @@
// ----------------------------------------------------------------------------
// mbt_pkg
// Types and constants shared by the metronome beat timer.
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    localparam int unsigned NUM_W   = 4;
    localparam int unsigned FREQ_W  = 12;
    localparam int unsigned TONE_W  = 8;
    localparam int unsigned TEMPO_W = 8;
    localparam int unsigned CD_W    = 12;
    localparam int unsigned DELTA_W = 4;

    localparam int unsigned DIV_N_W   = 16;
    localparam int unsigned DIV_D_W   = 8;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [DIV_N_W-1:0]   MS_PER_MINUTE = 16'd60000;
    localparam logic [CD_W-1:0]      BEAT_FIRST_MS = 12'd1000;
    localparam logic [TEMPO_W-1:0]   TEMPO_RESET   = 8'd60;
    localparam logic [TEMPO_W-1:0]   TEMPO_HIGH    = 8'd240;
    localparam logic [TEMPO_W-1:0]   TEMPO_LOW     = 8'd30;

    localparam logic [NUM_W-1:0]  NUM_FIRST_RESET  = 4'd4;
    localparam logic [NUM_W-1:0]  NUM_SECOND_RESET = 4'd3;
    localparam logic [FREQ_W-1:0] ACCENT_RESET     = 12'd880;
    localparam logic [FREQ_W-1:0] NORMAL_RESET     = 12'd440;
    localparam logic [TONE_W-1:0] TONE_LEN_RESET   = 8'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_FIRST  = 3'd0,
        CFG_NUM_SECOND = 3'd1,
        CFG_ACCENT     = 3'd2,
        CFG_NORMAL     = 3'd3,
        CFG_TONE_LEN   = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic              tone_active;
        logic [FREQ_W-1:0] tone_freq;
        logic              beat_fired;
        logic [NUM_W-1:0]  beat_number;
        logic [TEMPO_W-1:0] tempo_bpm;
        logic [NUM_W-1:0]  bar_length;
    } t_out_req;

endpackage

`default_nettype wire

@@ hw/rtl/mbt_if.sv @@
// ----------------------------------------------------------------------------
// mbt_in_if / mbt_out_if
// Valid/ready request channels of the metronome beat timer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbt_in_if;
    import mbt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [DELTA_W-1:0] bpm_delta;
    logic                      button_pressed;

    modport source (output valid, kind, bpm_delta, button_pressed, input ready);
    modport sink   (input valid, kind, bpm_delta, button_pressed, output ready);
endinterface

interface mbt_out_if;
    import mbt_pkg::*;

    logic               valid;
    logic               ready;
    logic               tone_active;
    logic [FREQ_W-1:0]  tone_freq;
    logic               beat_fired;
    logic [NUM_W-1:0]   beat_number;
    logic [TEMPO_W-1:0] tempo_bpm;
    logic [NUM_W-1:0]   bar_length;

    modport source (output valid, tone_active, tone_freq, beat_fired, beat_number,
                    tempo_bpm, bar_length, input ready);
    modport sink   (input valid, tone_active, tone_freq, beat_fired, beat_number,
                    tempo_bpm, bar_length, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mbt_div.sv @@
// ----------------------------------------------------------------------------
// mbt_div
// Restoring divider, one quotient bit per cycle, shared by the beat sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mbt_pkg::DIV_N_W-1:0] i_dividend,
    input  wire logic [mbt_pkg::DIV_D_W-1:0] i_divisor,
    output logic      [mbt_pkg::DIV_N_W-1:0] o_quotient,
    output logic      [mbt_pkg::DIV_D_W-1:0] o_remainder,
    output mbt_pkg::t_div_stat               o_stat
);
    import mbt_pkg::*;

    logic [DIV_N_W-1:0]   r_q;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    assign shifted = {r_rem, r_q[DIV_N_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_N_W-2:0], fits};
            r_rem <= fits ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
        end
    end

    assign o_quotient  = r_q;
    assign o_remainder = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

@@ hw/rtl/metronome_beat_timer_top.sv @@
// ----------------------------------------------------------------------------
// metronome_beat_timer_top
// Metronome beat generator driven by millisecond ticks and control samples.
// ----------------------------------------------------------------------------
// Every request yields one result request. A control sample, or a tick that
// fires no beat, is taken and its result is registered at once; the next
// request can follow in the next cycle when the result is taken. A tick that
// fires a beat starts the shared restoring divider, which runs two 16-step
// passes, first 60000 / tempo for the countdown reload, then the beat position
// wrap modulo the bar length. Each pass is started and then its result is
// picked up; after both passes the S_DONE state registers the result. The
// input stays not ready until the result is registered, and longer while the
// previous result waits.
`default_nettype none

module metronome_beat_timer_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    mbt_in_if.sink                              i_in,
    mbt_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [mbt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mbt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mbt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIVT = 4'b0010,
        S_DIVP = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    logic [NUM_W-1:0]   r_num_first;
    logic [NUM_W-1:0]   r_num_second;
    logic [FREQ_W-1:0]  r_accent;
    logic [FREQ_W-1:0]  r_normal;
    logic [TONE_W-1:0]  r_tone_len;

    t_state             r_state,     n_state;
    logic [TEMPO_W-1:0] r_tempo,     n_tempo;
    logic [NUM_W-1:0]   r_pos,       n_pos;
    logic               r_sig,       n_sig;
    logic               r_btn_prev,  n_btn_prev;
    logic [CD_W-1:0]    r_beat_cd,   n_beat_cd;
    logic [TONE_W-1:0]  r_tone_cd,   n_tone_cd;
    logic [FREQ_W-1:0]  r_last_freq, n_last_freq;
    logic [NUM_W-1:0]   r_sounded,   n_sounded;
    logic               r_out_valid, n_out_valid;
    t_out_req           r_out,       n_out;

    logic               accept;
    logic               out_free;
    logic [NUM_W-1:0]   num_sel;
    logic [NUM_W-1:0]   num_eff;
    logic [NUM_W-1:0]   num_next;
    logic [TEMPO_W-1:0] tempo_base;
    logic [TEMPO_W:0]   tempo_sum;
    logic               delta_pos;

    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic [DIV_N_W-1:0] div_quotient;
    logic [DIV_D_W-1:0] div_remainder;
    t_div_stat          div_stat;

    mbt_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder),
        .o_stat      (div_stat)
    );

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in.valid && i_in.ready;

    assign num_sel  = r_sig ? r_num_second : r_num_first;
    assign num_eff  = (num_sel == '0) ? NUM_W'(1) : num_sel;
    assign num_next = n_sig ? r_num_second : r_num_first;

    assign delta_pos = !i_in.bpm_delta[DELTA_W-1] && (i_in.bpm_delta != '0);

    always_comb begin
        if ((r_tempo >= TEMPO_HIGH) && delta_pos) begin
            tempo_base = TEMPO_LOW - 1'b1;
        end else if ((r_tempo <= TEMPO_LOW) && i_in.bpm_delta[DELTA_W-1]) begin
            tempo_base = TEMPO_HIGH + 1'b1;
        end else begin
            tempo_base = r_tempo;
        end
        tempo_sum = {1'b0, tempo_base}
                  + {{(TEMPO_W+1-DELTA_W){i_in.bpm_delta[DELTA_W-1]}}, i_in.bpm_delta};
    end

    always_comb begin
        n_state     = r_state;
        n_tempo     = r_tempo;
        n_pos       = r_pos;
        n_sig       = r_sig;
        n_btn_prev  = r_btn_prev;
        n_beat_cd   = r_beat_cd;
        n_tone_cd   = r_tone_cd;
        n_last_freq = r_last_freq;
        n_sounded   = r_sounded;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;

        div_start    = 1'b0;
        div_dividend = MS_PER_MINUTE;
        div_divisor  = DIV_D_W'(r_tempo);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_in.kind) begin
                        if (r_tone_cd != '0) begin
                            n_tone_cd = r_tone_cd - 1'b1;
                        end
                        if (r_beat_cd <= CD_W'(1)) begin
                            n_tone_cd   = r_tone_len;
                            n_last_freq = (r_pos == '0) ? r_accent : r_normal;
                            n_sounded   = r_pos;
                            div_start   = 1'b1;
                            n_state     = S_DIVT;
                        end else begin
                            n_beat_cd = r_beat_cd - 1'b1;
                        end
                    end else begin
                        n_tempo = tempo_sum[TEMPO_W-1:0];
                        if (i_in.button_pressed && !r_btn_prev) begin
                            n_sig = !r_sig;
                            n_pos = '0;
                        end
                        n_btn_prev = i_in.button_pressed;
                    end
                    if (n_state == S_IDLE) begin
                        n_out_valid       = 1'b1;
                        n_out.tone_active = (n_tone_cd != '0);
                        n_out.tone_freq   = r_last_freq;
                        n_out.beat_fired  = 1'b0;
                        n_out.beat_number = '0;
                        n_out.tempo_bpm   = n_tempo;
                        n_out.bar_length  = num_next;
                    end
                end
            end
            S_DIVT: begin
                if (div_stat.done) begin
                    n_beat_cd    = div_quotient[CD_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = DIV_N_W'({1'b0, r_pos} + 1'b1);
                    div_divisor  = DIV_D_W'(num_eff);
                    n_state      = S_DIVP;
                end
            end
            S_DIVP: begin
                if (div_stat.done) begin
                    n_pos   = div_remainder[NUM_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.tone_active = (r_tone_cd != '0);
                    n_out.tone_freq   = r_last_freq;
                    n_out.beat_fired  = 1'b1;
                    n_out.beat_number = r_sounded;
                    n_out.tempo_bpm   = r_tempo;
                    n_out.bar_length  = num_sel;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tempo     <= TEMPO_RESET;
            r_pos       <= '0;
            r_sig       <= 1'b0;
            r_btn_prev  <= 1'b0;
            r_beat_cd   <= BEAT_FIRST_MS;
            r_tone_cd   <= '0;
            r_last_freq <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tempo     <= n_tempo;
            r_pos       <= n_pos;
            r_sig       <= n_sig;
            r_btn_prev  <= n_btn_prev;
            r_beat_cd   <= n_beat_cd;
            r_tone_cd   <= n_tone_cd;
            r_last_freq <= n_last_freq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sounded <= n_sounded;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_first  <= NUM_FIRST_RESET;
            r_num_second <= NUM_SECOND_RESET;
            r_accent     <= ACCENT_RESET;
            r_normal     <= NORMAL_RESET;
            r_tone_len   <= TONE_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_FIRST:  r_num_first  <= i_cfg_data[NUM_W-1:0];
                CFG_NUM_SECOND: r_num_second <= i_cfg_data[NUM_W-1:0];
                CFG_ACCENT:     r_accent     <= i_cfg_data[FREQ_W-1:0];
                CFG_NORMAL:     r_normal     <= i_cfg_data[FREQ_W-1:0];
                CFG_TONE_LEN:   r_tone_len   <= i_cfg_data[TONE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.tone_active = r_out.tone_active;
    assign o_out.tone_freq   = r_out.tone_freq;
    assign o_out.beat_fired  = r_out.beat_fired;
    assign o_out.beat_number = r_out.beat_number;
    assign o_out.tempo_bpm   = r_out.tempo_bpm;
    assign o_out.bar_length  = r_out.bar_length;

endmodule

`default_nettype wire

@@ hw/rtl/mbt_checker.sv @@
// ----------------------------------------------------------------------------
// mbt_checker
// Port-level assertions for the metronome beat timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "metronome_beat_timer_top_assert.svh"

module mbt_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic                         i_out_beat_fired,
    input wire logic [mbt_pkg::NUM_W-1:0]    i_out_beat_number,
    input wire logic [mbt_pkg::TEMPO_W-1:0]  i_out_tempo_bpm,
    input wire logic [mbt_pkg::FREQ_W-1:0]   i_out_tone_freq
);
    import mbt_pkg::*;

    `MBT_ASSERT_NOW(a_no_beat_zero_number, i_out_valid && !i_out_beat_fired, i_out_beat_number == '0, "beat number set without a beat")
    `MBT_ASSERT_NOW(a_beat_number_range, i_out_valid && i_out_beat_fired, i_out_beat_number != {NUM_W{1'b1}}, "beat number out of range")
    `MBT_ASSERT_NOW(a_tempo_range, i_out_valid, (i_out_tempo_bpm >= 8'd23) && (i_out_tempo_bpm <= 8'd246), "tempo out of range")
    `MBT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_tempo_bpm) && $stable(i_out_tone_freq), "stalled result changed")

endmodule

bind metronome_beat_timer_top mbt_checker u_mbt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_beat_fired  (o_out.beat_fired),
    .i_out_beat_number (o_out.beat_number),
    .i_out_tempo_bpm   (o_out.tempo_bpm),
    .i_out_tone_freq   (o_out.tone_freq)
);

`default_nettype wire
